@@ hw/rtl/sls_pkg.sv @@
// ----------------------------------------------------------------------------
// sls_pkg
// shared types, constants and the modulus fold of the shuffled lcg source
// ----------------------------------------------------------------------------
package sls_pkg;

  localparam int WORD_W = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = WORD_W + MULT_W;

  localparam logic [WORD_W-1:0] LCG_MOD  = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0] LCG_MULT = 15'd16807;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_MUL,
    ST_SEED_FOLD,
    ST_SEED_LAST,
    ST_DRAW_RD,
    ST_DRAW_WB
  } state_t;

  // product mod 2^31-1: add high part to low part, one conditional subtract
  function automatic word_t mod_fold(input logic [PROD_W-1:0] p);
    logic [WORD_W:0] s;
    logic [WORD_W:0] d;
    s = {1'b0, p[WORD_W-1:0]} + {{(2*WORD_W-PROD_W+1){1'b0}}, p[PROD_W-1:WORD_W]};
    d = s - {1'b0, LCG_MOD};
    if (s >= {1'b0, LCG_MOD}) begin
      mod_fold = d[WORD_W-1:0];
    end else begin
      mod_fold = s[WORD_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/sls_ram.sv @@
// ----------------------------------------------------------------------------
// sls_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module sls_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/shuffled_lcg_random_source.sv @@
// ----------------------------------------------------------------------------
// shuffled_lcg_random_source
// park-miller generator (x*16807 mod 2^31-1) behind a shuffle table in ram
// ----------------------------------------------------------------------------
// a draw steps through ST_DRAW_RD and ST_DRAW_WB; its result is registered at
// write-back, which stalls while an earlier result waits on out_ready, and a
// new request can be taken during that write-back. a reseed, or the first request
// after reset, first fills the table: each generator step is a multiply then a fold
// reset clears the control state; the table is undefined until the first
// request seeds it
module shuffled_lcg_random_source #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_command,
  input  logic [sls_pkg::WORD_W-1:0] in_seed,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [sls_pkg::WORD_W-1:0] out_value
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int Q_W   = IDX_W + 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 8);
  localparam longint unsigned IDX_DIV = 64'd1 + 64'd2147483646 / TABLE_ENTRIES;
  localparam int DIV_L = $clog2(IDX_DIV);
  localparam int SHIFT = sls_pkg::WORD_W + DIV_L;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + IDX_DIV - 64'd1) / IDX_DIV;
  localparam logic [32:0] RECIP = RECIP_L[32:0];

  sls_pkg::state_t state_r, state_nxt;
  sls_pkg::word_t  gen_r, gen_nxt;
  sls_pkg::word_t  out_value_r, out_value_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            seeded_r, seeded_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [sls_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic [63:0]     recip_r, recip_nxt;

  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  sls_pkg::word_t  mem_wdata;
  sls_pkg::word_t  mem_rdata;
  logic [IDX_W-1:0] idx;
  logic [Q_W-1:0]  idx_q;
  sls_pkg::word_t  fold;
  sls_pkg::word_t  seed_fix;
  sls_pkg::word_t  recip_src;
  logic            can_finish;
  logic            accept;

  sls_ram #(
    .WIDTH(sls_pkg::WORD_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx),
    .rdata(mem_rdata)
  );

  // table index of the last output, from its registered reciprocal product
  assign idx_q = recip_r[SHIFT +: Q_W];
  assign idx   = (idx_q >= Q_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1)
                                                : idx_q[IDX_W-1:0];

  assign fold       = sls_pkg::mod_fold(prod_r);
  assign seed_fix   = (in_seed == '0 || in_seed == sls_pkg::LCG_MOD) ? 31'd1 : in_seed;
  assign can_finish = !out_valid_r || out_ready;
  assign in_ready   = (state_r == sls_pkg::ST_IDLE) ||
                      (state_r == sls_pkg::ST_DRAW_WB && can_finish);
  assign accept     = in_valid && in_ready;
  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ready;
    seeded_nxt    = seeded_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    recip_nxt     = recip_r;
    recip_src     = mem_rdata;
    mem_we        = 1'b0;
    mem_waddr     = idx;
    mem_wdata     = fold;

    unique case (state_r)
      sls_pkg::ST_IDLE: begin
      end
      sls_pkg::ST_SEED_MUL: begin
        prod_nxt  = {{sls_pkg::MULT_W{1'b0}}, gen_r} *
                    {{sls_pkg::WORD_W{1'b0}}, sls_pkg::LCG_MULT};
        state_nxt = sls_pkg::ST_SEED_FOLD;
      end
      sls_pkg::ST_SEED_FOLD: begin
        gen_nxt = fold;
        if (cnt_r < CNT_W'(TABLE_ENTRIES)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[IDX_W-1:0];
        end
        if (cnt_r == '0) begin
          state_nxt = sls_pkg::ST_SEED_LAST;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = sls_pkg::ST_SEED_MUL;
        end
      end
      sls_pkg::ST_SEED_LAST: begin
        // last output equals entry 0, which is the final generator word
        recip_src  = gen_r;
        recip_nxt  = 64'(recip_src) * 64'(RECIP);
        seeded_nxt = 1'b1;
        state_nxt  = sls_pkg::ST_DRAW_RD;
      end
      sls_pkg::ST_DRAW_RD: begin
        prod_nxt  = {{sls_pkg::MULT_W{1'b0}}, gen_r} *
                    {{sls_pkg::WORD_W{1'b0}}, sls_pkg::LCG_MULT};
        state_nxt = sls_pkg::ST_DRAW_WB;
      end
      sls_pkg::ST_DRAW_WB: begin
        if (can_finish) begin
          gen_nxt       = fold;
          mem_we        = 1'b1;
          out_value_nxt = mem_rdata;
          out_valid_nxt = 1'b1;
          recip_nxt     = 64'(recip_src) * 64'(RECIP);
          state_nxt     = sls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sls_pkg::ST_IDLE;
      end
    endcase

    // new transaction, taken in idle or while the previous draw writes back
    if (accept) begin
      if (in_command || !seeded_r) begin
        gen_nxt   = seed_fix;
        cnt_nxt   = CNT_W'(TABLE_ENTRIES + 7);
        state_nxt = sls_pkg::ST_SEED_MUL;
      end else begin
        state_nxt = sls_pkg::ST_DRAW_RD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sls_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      seeded_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      seeded_r    <= seeded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r       <= gen_nxt;
    out_value_r <= out_value_nxt;
    cnt_r       <= cnt_nxt;
    prod_r      <= prod_nxt;
    recip_r     <= recip_nxt;
  end

  a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |-> (gen_r != '0 && gen_r != sls_pkg::LCG_MOD))
    else $error("generator word out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (seeded_r && state_r == sls_pkg::ST_DRAW_RD) |-> (idx_q < Q_W'(TABLE_ENTRIES)))
    else $error("shuffle index quotient out of range");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=>
      (state_r == sls_pkg::ST_SEED_MUL || state_r == sls_pkg::ST_DRAW_RD))
    else $error("transaction did not start seed or draw");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == sls_pkg::ST_DRAW_WB))
    else $error("result raised outside write-back");

endmodule
